@@ src/mmcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcw_pkg
// Shared constants, register codes and pair indexing for the minimum
// monochromatic cut weight unit.
// ----------------------------------------------------------------------------
package mmcw_pkg;

    localparam int NODES   = 8;
    localparam int PAIRS   = NODES * (NODES - 1) / 2;
    localparam int PAIR_W  = $clog2(PAIRS);
    localparam int CUTS    = 1 << (NODES - 1);
    localparam int CUT_W   = NODES - 1;
    localparam int OUT_W   = 21;
    localparam int CFG_W   = PAIRS;
    localparam int NC_W    = 4;
    localparam int TW_W    = 8;
    localparam int FACTOR  = 25;
    localparam int LATENCY = (NODES - 1) + CUT_W + 2;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT   = 2'd0,
        CFG_ADJACENCY    = 2'd1,
        CFG_TOTAL_WEIGHT = 2'd2
    } t_cfg_idx;

    function automatic logic [PAIR_W-1:0] pair_idx(input int i, input int j);
        pair_idx = PAIR_W'(j * (j - 1) / 2 + i);
    endfunction

endpackage

`default_nettype wire

@@ src/min_monochromatic_cut_weight_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_monochromatic_cut_weight_unit
// Minimum monochromatic edge weight-product sum over all 2-colorings of a
// configured graph, with a threshold violation flag.
// ----------------------------------------------------------------------------
// One weight vector is taken every cycle and o_busy is low except in reset.
// Each request gives one result after these registered steps: the edge
// products, the chain of seven cells, one for each vertex but vertex 0,
// that builds all 128 coloring sums, seven levels of the registered
// minimum tree and the threshold compare. The result is shown
// for one cycle with o_done and the receiver cannot stall it. Configuration
// writes take effect at once and belong only to idle periods.
// ----------------------------------------------------------------------------
module min_monochromatic_cut_weight_unit
    import mmcw_pkg::*;
#(
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_0,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_1,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_2,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_3,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_4,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_5,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_6,
    input  wire logic [WEIGHT_BITS-1:0] i_weight_7,
    output logic                        o_done,
    output logic [OUT_W-1:0]            o_min_mono_sum,
    output logic                        o_violation
);

    localparam int PROD_W = 2 * WEIGHT_BITS;
    localparam int SUM_W  = PROD_W + $clog2(PAIRS);
    localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int MUL_W  = SUM_W + 5;
    localparam int CMP_W  = (MUL_W > 2 * TW_W) ? MUL_W : 2 * TW_W;

    logic [NC_W-1:0]  r_node_count;
    logic [CFG_W-1:0] r_adjacency;
    logic [TW_W-1:0]  r_total_weight;

    logic [WEIGHT_BITS-1:0]       w [NODES];
    logic [PAIRS-1:0][PROD_W-1:0] n_prod;
    logic                         accept;

    logic                         r_stage_vld;
    logic [PAIRS-1:0][PROD_W-1:0] r_stage_prod;

    logic                         stage_vld  [NODES];
    logic [PAIRS-1:0][PROD_W-1:0] stage_prod [NODES];
    logic [CUTS-1:0][SUM_W-1:0]   stage_sum  [NODES];

    logic             tree_vld;
    logic [SUM_W-1:0] tree_min;
    logic [EXT_W-1:0] min_ext;
    logic [CMP_W-1:0] scaled;
    logic [CMP_W-1:0] limit;

    logic             r_done;
    logic [OUT_W-1:0] r_sum;
    logic             r_viol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count   <= NC_W'(8);
            r_adjacency    <= '0;
            r_total_weight <= TW_W'(20);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_COUNT:   r_node_count   <= i_cfg_data[NC_W-1:0];
                CFG_ADJACENCY:    r_adjacency    <= i_cfg_data;
                CFG_TOTAL_WEIGHT: r_total_weight <= i_cfg_data[TW_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    assign w[0] = i_weight_0;
    assign w[1] = i_weight_1;
    assign w[2] = i_weight_2;
    assign w[3] = i_weight_3;
    assign w[4] = i_weight_4;
    assign w[5] = i_weight_5;
    assign w[6] = i_weight_6;
    assign w[7] = i_weight_7;

    always_comb begin
        for (int j = 1; j < NODES; j++) begin
            for (int i = 0; i < j; i++) begin
                if (r_adjacency[pair_idx(i, j)] && (NC_W'(j) < r_node_count)) begin
                    n_prod[pair_idx(i, j)] = PROD_W'(w[i]) * PROD_W'(w[j]);
                end else begin
                    n_prod[pair_idx(i, j)] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_vld <= 1'b0;
        end else begin
            r_stage_vld <= accept;
        end
        r_stage_prod <= n_prod;
    end

    assign stage_vld[0]  = r_stage_vld;
    assign stage_prod[0] = r_stage_prod;
    assign stage_sum[0]  = '0;

    for (genvar c = 1; c < NODES; c++) begin : g_cell
        mmcw_cell #(
            .J      (c),
            .PROD_W (PROD_W),
            .SUM_W  (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_vld[c-1]),
            .i_prod  (stage_prod[c-1]),
            .i_sum   (stage_sum[c-1]),
            .o_valid (stage_vld[c]),
            .o_prod  (stage_prod[c]),
            .o_sum   (stage_sum[c])
        );
    end

    mmcw_min_tree #(
        .SUM_W (SUM_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_vld[NODES-1]),
        .i_leaf  (stage_sum[NODES-1]),
        .o_valid (tree_vld),
        .o_min   (tree_min)
    );

    assign min_ext = EXT_W'(tree_min);
    assign scaled  = (CMP_W'(tree_min) << 4) + (CMP_W'(tree_min) << 3) + CMP_W'(tree_min);
    assign limit   = CMP_W'(r_total_weight) * CMP_W'(r_total_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= tree_vld;
        end
        r_sum  <= min_ext[OUT_W-1:0];
        r_viol <= scaled > limit;
    end

    assign o_done         = r_done;
    assign o_min_mono_sum = r_sum;
    assign o_violation    = r_viol;

endmodule

`default_nettype wire

@@ src/mmcw_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcw_cell
// One vertex of the chain: extends every partial coloring by the side of
// vertex J and adds the products of its same-side edges.
// ----------------------------------------------------------------------------
module mmcw_cell
    import mmcw_pkg::*;
#(
    parameter int J      = 1,
    parameter int PROD_W = 16,
    parameter int SUM_W  = 21
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [PAIRS-1:0][PROD_W-1:0]   i_prod,
    input  wire logic [CUTS-1:0][SUM_W-1:0]     i_sum,
    output logic                                o_valid,
    output logic      [PAIRS-1:0][PROD_W-1:0]   o_prod,
    output logic      [CUTS-1:0][SUM_W-1:0]     o_sum
);

    localparam int                   OUT_CUTS  = 1 << J;
    localparam logic [CUT_W-1:0]     HALF_MASK = CUT_W'((1 << (J - 1)) - 1);

    logic                            r_valid;
    logic [PAIRS-1:0][PROD_W-1:0]    r_prod;
    logic [CUTS-1:0][SUM_W-1:0]      r_sum;
    logic [CUTS-1:0][SUM_W-1:0]      n_sum;

    always_comb begin
        logic [CUT_W-1:0] kk;
        logic [SUM_W-1:0] acc;
        logic             side_j;
        logic             side_i;
        for (int k = 0; k < CUTS; k++) begin
            kk = CUT_W'(k);
            acc = '0;
            side_j = 1'b0;
            side_i = 1'b0;
            if (k < OUT_CUTS) begin
                acc = i_sum[kk & HALF_MASK];
                side_j = kk[J-1];
                for (int i = 0; i < J; i++) begin
                    side_i = (i == 0) ? 1'b0 : kk[(i == 0) ? 0 : i - 1];
                    if (side_i == side_j) begin
                        acc = acc + SUM_W'(i_prod[pair_idx(i, J)]);
                    end
                end
            end
            n_sum[k] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prod <= i_prod;
        r_sum  <= n_sum;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

@@ src/mmcw_min_tree.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcw_min_tree
// Registered binary minimum tree over all coloring sums, one level per cycle.
// ----------------------------------------------------------------------------
module mmcw_min_tree
    import mmcw_pkg::*;
#(
    parameter int SUM_W = 21
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [CUTS-1:0][SUM_W-1:0]  i_leaf,
    output logic                             o_valid,
    output logic      [SUM_W-1:0]            o_min
);

    logic [SUM_W-1:0] r_heap [1:CUTS-1];
    logic [SUM_W-1:0] n_heap [1:CUTS-1];
    logic [CUT_W-1:0] r_vld;

    for (genvar k = 1; k < CUTS; k++) begin : g_node
        logic [SUM_W-1:0] lhs;
        logic [SUM_W-1:0] rhs;
        if (2 * k >= CUTS) begin : g_leaf
            assign lhs = i_leaf[2 * k - CUTS];
            assign rhs = i_leaf[2 * k + 1 - CUTS];
        end else begin : g_inner
            assign lhs = r_heap[2 * k];
            assign rhs = r_heap[2 * k + 1];
        end
        assign n_heap[k] = (rhs < lhs) ? rhs : lhs;

        always_ff @(posedge i_clk) begin
            r_heap[k] <= n_heap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CUT_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[CUT_W-1];
    assign o_min   = r_heap[1];

endmodule

`default_nettype wire

@@ src/mmcw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcw_checker
// Port-level timing checks for the minimum monochromatic cut weight unit.
// ----------------------------------------------------------------------------
module mmcw_checker
    import mmcw_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done
);

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("request without result");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without request");

    a_reset_flushes: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

endmodule

bind min_monochromatic_cut_weight_unit mmcw_checker u_mmcw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done)
);

`default_nettype wire

@@ tb/min_monochromatic_cut_weight_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_monochromatic_cut_weight_unit_tb
// Streams weight vectors into the unit under a series of graph, node count and
// denominator settings. The expected minimum cut sum and violation flag come
// from a brute-force search over all colorings with vertex 0 pinned to side 0.
// Every strobed result is checked in order against that search. Settings
// change only after the pipeline has drained.
// ----------------------------------------------------------------------------
module min_monochromatic_cut_weight_unit_tb
    import mmcw_pkg::*;
();

    localparam int W_BITS         = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 17;
    localparam int PHASE_REQUESTS = 100;

    typedef logic [NODES-1:0][W_BITS-1:0] t_weights;

    typedef struct packed {
        logic [OUT_W-1:0] min_sum;
        logic             violation;
    } t_cut_result;

    class cut_scoreboard;
        logic [NC_W-1:0]  node_count;
        logic [CFG_W-1:0] adjacency;
        logic [TW_W-1:0]  total_weight;
        t_cut_result      pending_q[$];
        int               errors;

        function new();
            node_count   = NC_W'(8);
            adjacency    = '0;
            total_weight = TW_W'(20);
            errors       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_NODE_COUNT:   node_count = data[NC_W-1:0];
                CFG_ADJACENCY:    adjacency = data;
                CFG_TOTAL_WEIGHT: total_weight = data[TW_W-1:0];
                default: ;
            endcase
        endfunction

        function t_cut_result min_cut(t_weights w);
            int                active;
            int                m;
            int                i;
            int                j;
            longint unsigned   best;
            longint unsigned   s;
            longint unsigned   threshold;
            logic [NODES-1:0]  side;
            t_cut_result       r;
            active = int'(node_count);
            if (active > NODES) active = NODES;
            if (active < 1) active = 1;
            best = '1;
            for (m = 0; m < (1 << (active - 1)); m++) begin
                side = NODES'(m << 1);
                s = 0;
                for (j = 1; j < active; j++) begin
                    for (i = 0; i < j; i++) begin
                        if (adjacency[j * (j - 1) / 2 + i] && side[i] == side[j]) begin
                            s += 64'(w[i]) * 64'(w[j]);
                        end
                    end
                end
                if (s < best) best = s;
            end
            threshold   = 64'(total_weight) * 64'(total_weight);
            r.min_sum   = best[OUT_W-1:0];
            r.violation = (64'(FACTOR) * best > threshold);
            return r;
        endfunction

        function void note_request(t_weights w);
            pending_q = {pending_q, min_cut(w)};
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [OUT_W-1:0] sum, logic viol);
            t_cut_result want;
            if (pending_q.size() == 0) begin
                complain($sformatf("unexpected result sum=%0d violation=%0b", sum, viol));
            end else begin
                want = pending_q.pop_front();
                if (sum !== want.min_sum)
                    complain($sformatf("min_mono_sum expected %0d got %0d",
                                       want.min_sum, sum));
                if (viol !== want.violation)
                    complain($sformatf("violation expected %0b got %0b",
                                       want.violation, viol));
            end
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_idx  = CFG_NODE_COUNT;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_start    = 1'b0;
    t_weights         req_weights = '0;
    logic             o_busy;
    logic             o_done;
    logic [OUT_W-1:0] o_min_mono_sum;
    logic             o_violation;
    int               cycle_count = 0;

    cut_scoreboard board = new();

    min_monochromatic_cut_weight_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_weight_0     (req_weights[0]),
        .i_weight_1     (req_weights[1]),
        .i_weight_2     (req_weights[2]),
        .i_weight_3     (req_weights[3]),
        .i_weight_4     (req_weights[4]),
        .i_weight_5     (req_weights[5]),
        .i_weight_6     (req_weights[6]),
        .i_weight_7     (req_weights[7]),
        .o_done         (o_done),
        .o_min_mono_sum (o_min_mono_sum),
        .o_violation    (o_violation)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_start && !o_busy) board.note_request(req_weights);
            if (o_done) board.check_result(o_min_mono_sum, o_violation);
        end
    end

    task automatic send_request(t_weights w, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start     <= 1'b1;
        req_weights <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // hold off until every request in flight has returned
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (board.pending_q.size() != 0);
    endtask

    task automatic apply_settings(logic [NC_W-1:0] nc, logic [CFG_W-1:0] adj,
                                  logic [TW_W-1:0] tw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_COUNT;
        i_cfg_data <= CFG_W'(nc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ADJACENCY;
        i_cfg_data <= adj;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOTAL_WEIGHT;
        i_cfg_data <= CFG_W'(tw);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_weights random_weights();
        t_weights w;
        int       k;
        int       shape;
        shape = $urandom_range(3);
        for (k = 0; k < NODES; k++) begin
            case (shape)
                0:       w[k] = W_BITS'($urandom_range(15));
                1:       w[k] = ($urandom_range(3) == 0) ? W_BITS'($urandom()) : '0;
                default: w[k] = W_BITS'($urandom());
            endcase
        end
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] random_adjacency();
        case ($urandom_range(3))
            0:       return CFG_W'($urandom() & $urandom());
            1:       return CFG_W'($urandom() | $urandom());
            2:       return '1;
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [NC_W-1:0] random_node_count();
        int r;
        r = $urandom_range(99);
        if (r < 10) return NC_W'($urandom_range(15));
        if (r < 45) return NC_W'(8);
        return NC_W'($urandom_range(2, 8));
    endfunction

    function automatic logic [TW_W-1:0] random_total_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return TW_W'($urandom_range(1, 20));
            default: return TW_W'($urandom_range(1, 255));
        endcase
    endfunction

    initial begin
        int          phase;
        int          k;
        int          idle_pct;
        t_weights    w;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no edges at all
        send_request({NODES{8'hFF}}, 0);
        send_request('0, 0);
        drain();

        // complete graph, widest denominator
        apply_settings(NC_W'(8), '1, TW_W'(255));
        send_request({NODES{8'hFF}}, 0);
        send_request('0, 0);
        send_request(t_weights'(8'hFF), 0);
        send_request({NODES{8'h55}}, 0);
        send_request({NODES{8'hAA}}, 0);
        send_request({8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1}, 0);
        drain();

        // node count beyond the array, zero denominator
        apply_settings(NC_W'(15), '1, '0);
        send_request({NODES{8'hFF}}, 0);
        send_request({NODES{8'h01}}, 0);
        send_request('0, 0);
        drain();

        // only vertex 0 in use
        apply_settings('0, '1, '0);
        send_request({NODES{8'hFF}}, 0);
        drain();
        apply_settings(NC_W'(1), '1, '0);
        send_request({NODES{8'hFF}}, 0);
        drain();

        apply_settings(NC_W'(2), CFG_W'(1), TW_W'(1));
        send_request({NODES{8'hFF}}, 0);
        send_request({NODES{8'h01}}, 0);
        drain();

        // weights of unused vertices must not matter
        apply_settings(NC_W'(5), '1, TW_W'(20));
        w = random_weights();
        w[7] = 8'hFF;
        w[6] = 8'hFF;
        w[5] = 8'hFF;
        send_request(w, 0);
        w[7] = '0;
        w[6] = '0;
        w[5] = '0;
        send_request(w, 0);
        send_request({NODES{8'h0F}}, 0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            apply_settings(random_node_count(), random_adjacency(), random_total_weight());
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 79;
                default: idle_pct = 6;
            endcase
            for (k = 0; k < PHASE_REQUESTS; k++) begin
                send_request(random_weights(), idle_pct);
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        board.errors += board.pending_q.size();
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
